[design/leb_pkg.sv]
// ----------------------------------------------------------------------------
// leb_pkg: shared types, constants and microcode for the line edit buffer
// Holds the op codes, control word layout, the program ROM and the op
// dispatch table used by the sequencer and the datapath.
// ----------------------------------------------------------------------------
package leb_pkg;

  localparam int MAX_UNITS = 64;
  localparam int LEN_W     = $clog2(MAX_UNITS + 1);  // holds 0..MAX_UNITS
  localparam int ADDR_W    = $clog2(MAX_UNITS);      // line store address
  localparam int UNIT_W    = 16;
  localparam int OP_W      = 4;
  localparam int UA_W      = 5;   // microcode address width

  localparam logic [LEN_W-1:0] MAX_LEN_RST = LEN_W'(MAX_UNITS);

  // edit commands
  localparam logic [OP_W-1:0] OP_INSERT    = 4'd1;
  localparam logic [OP_W-1:0] OP_BACKSPACE = 4'd2;
  localparam logic [OP_W-1:0] OP_DELETE    = 4'd3;
  localparam logic [OP_W-1:0] OP_LEFT      = 4'd4;
  localparam logic [OP_W-1:0] OP_RIGHT     = 4'd5;
  localparam logic [OP_W-1:0] OP_HOME      = 4'd6;
  localparam logic [OP_W-1:0] OP_END       = 4'd7;
  localparam logic [OP_W-1:0] OP_COMMIT    = 4'd8;
  localparam logic [OP_W-1:0] OP_CANCEL    = 4'd9;
  localparam logic [OP_W-1:0] OP_READ      = 4'd10;

  // jump conditions
  localparam logic [2:0] C_NONE       = 3'd0;
  localparam logic [2:0] C_ALWAYS     = 3'd1;
  localparam logic [2:0] C_FULL       = 3'd2;
  localparam logic [2:0] C_CARET_ZERO = 3'd3;
  localparam logic [2:0] C_CARET_END  = 3'd4;
  localparam logic [2:0] C_MORE_INS   = 3'd5;
  localparam logic [2:0] C_MORE_DEL   = 3'd6;
  localparam logic [2:0] C_OUT_BUSY   = 3'd7;

  // pointer load source
  localparam logic [1:0] PTR_KEEP     = 2'd0;
  localparam logic [1:0] PTR_LEN      = 2'd1;
  localparam logic [1:0] PTR_CARET    = 2'd2;
  localparam logic [1:0] PTR_CARET_M1 = 2'd3;

  // shift direction
  localparam logic [1:0] SH_NONE = 2'd0;
  localparam logic [1:0] SH_INS  = 2'd1;  // move tail right, walk down
  localparam logic [1:0] SH_DEL  = 2'd2;  // move tail left, walk up

  // length update
  localparam logic [1:0] LEN_KEEP = 2'd0;
  localparam logic [1:0] LEN_INC  = 2'd1;
  localparam logic [1:0] LEN_DEC  = 2'd2;

  // caret update
  localparam logic [2:0] CAR_KEEP   = 3'd0;
  localparam logic [2:0] CAR_INC    = 3'd1;
  localparam logic [2:0] CAR_DEC    = 3'd2;
  localparam logic [2:0] CAR_ZERO   = 3'd3;
  localparam logic [2:0] CAR_TO_LEN = 3'd4;
  localparam logic [2:0] CAR_RIGHT  = 3'd5;  // increment unless at end
  localparam logic [2:0] CAR_LEFT   = 3'd6;  // decrement unless at zero

  // microcode addresses
  localparam logic [UA_W-1:0] UA_DONE   = 5'd0;
  localparam logic [UA_W-1:0] UA_REFUSE = 5'd1;
  localparam logic [UA_W-1:0] UA_I0     = 5'd2;
  localparam logic [UA_W-1:0] UA_I1     = 5'd3;
  localparam logic [UA_W-1:0] UA_I2     = 5'd4;
  localparam logic [UA_W-1:0] UA_I3     = 5'd5;
  localparam logic [UA_W-1:0] UA_B0     = 5'd6;
  localparam logic [UA_W-1:0] UA_B1     = 5'd7;
  localparam logic [UA_W-1:0] UA_B2     = 5'd8;
  localparam logic [UA_W-1:0] UA_D0     = 5'd9;
  localparam logic [UA_W-1:0] UA_D1     = 5'd10;
  localparam logic [UA_W-1:0] UA_D2     = 5'd11;
  localparam logic [UA_W-1:0] UA_LEFT   = 5'd12;
  localparam logic [UA_W-1:0] UA_RIGHT  = 5'd13;
  localparam logic [UA_W-1:0] UA_HOME   = 5'd14;
  localparam logic [UA_W-1:0] UA_END    = 5'd15;
  localparam logic [UA_W-1:0] UA_COMMIT = 5'd16;
  localparam logic [UA_W-1:0] UA_CANCEL = 5'd17;
  localparam logic [UA_W-1:0] UA_READ   = 5'd18;

  typedef struct packed {
    logic [2:0]      cond;
    logic [UA_W-1:0] target;
    logic [1:0]      ptr_sel;
    logic [1:0]      shift;
    logic            wr_unit;
    logic [1:0]      len_op;
    logic [2:0]      caret_op;
    logic            set_commit;
    logic            set_cancel;
    logic            set_refused;
    logic            rd_issue;
    logic            emit;
  } ucode_t;

  // sequencer -> datapath
  typedef struct packed {
    logic       accept;
    logic [1:0] ptr_sel;
    logic [1:0] shift;
    logic       wr_unit;
    logic [1:0] len_op;
    logic [2:0] caret_op;
    logic       set_commit;
    logic       set_cancel;
    logic       set_refused;
    logic       rd_issue;
    logic       emit;
  } ctrl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic full;
    logic caret_zero;
    logic caret_end;
    logic more_ins;
    logic more_del;
    logic out_busy;
  } stat_t;

  function automatic ucode_t ucode_rom(input logic [UA_W-1:0] addr);
    ucode_t w;
    w        = '0;
    w.cond   = C_ALWAYS;
    w.target = UA_DONE;
    case (addr)
      UA_DONE: begin
        w.cond = C_OUT_BUSY;
        w.emit = 1'b1;
      end
      UA_REFUSE: begin
        w.set_refused = 1'b1;
      end
      UA_I0: begin
        w.cond    = C_FULL;
        w.target  = UA_REFUSE;
        w.ptr_sel = PTR_LEN;
      end
      UA_I1: begin
        w.cond   = C_MORE_INS;
        w.target = UA_I1;
        w.shift  = SH_INS;
      end
      UA_I2: begin
        w.cond = C_NONE;  // last shifted unit lands here
      end
      UA_I3: begin
        w.wr_unit  = 1'b1;
        w.len_op   = LEN_INC;
        w.caret_op = CAR_INC;
      end
      UA_B0: begin
        w.cond    = C_CARET_ZERO;
        w.ptr_sel = PTR_CARET_M1;
      end
      UA_B1: begin
        w.cond   = C_MORE_DEL;
        w.target = UA_B1;
        w.shift  = SH_DEL;
      end
      UA_B2: begin
        w.len_op   = LEN_DEC;
        w.caret_op = CAR_DEC;
      end
      UA_D0: begin
        w.cond    = C_CARET_END;
        w.ptr_sel = PTR_CARET;
      end
      UA_D1: begin
        w.cond   = C_MORE_DEL;
        w.target = UA_D1;
        w.shift  = SH_DEL;
      end
      UA_D2: begin
        w.len_op = LEN_DEC;
      end
      UA_LEFT:   w.caret_op   = CAR_LEFT;
      UA_RIGHT:  w.caret_op   = CAR_RIGHT;
      UA_HOME:   w.caret_op   = CAR_ZERO;
      UA_END:    w.caret_op   = CAR_TO_LEN;
      UA_COMMIT: w.set_commit = 1'b1;
      UA_CANCEL: w.set_cancel = 1'b1;
      UA_READ:   w.rd_issue   = 1'b1;
      default:   w.cond       = C_ALWAYS;
    endcase
    return w;
  endfunction

  function automatic logic [UA_W-1:0] op_entry(input logic [OP_W-1:0] op);
    logic [UA_W-1:0] a;
    case (op)
      OP_INSERT:    a = UA_I0;
      OP_BACKSPACE: a = UA_B0;
      OP_DELETE:    a = UA_D0;
      OP_LEFT:      a = UA_LEFT;
      OP_RIGHT:     a = UA_RIGHT;
      OP_HOME:      a = UA_HOME;
      OP_END:       a = UA_END;
      OP_COMMIT:    a = UA_COMMIT;
      OP_CANCEL:    a = UA_CANCEL;
      OP_READ:      a = UA_READ;
      default:      a = UA_DONE;
    endcase
    return a;
  endfunction

  // zero or anything above the store size selects the full store
  function automatic logic [LEN_W-1:0] clamp_max(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    if ((v == '0) || (v > MAX_LEN_RST)) begin
      r = MAX_LEN_RST;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[design/leb_sequencer.sv]
// ----------------------------------------------------------------------------
// leb_sequencer: microprogram sequencer
// Step counter over the program ROM, op dispatch on acceptance and
// conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module leb_sequencer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [leb_pkg::OP_W-1:0]   in_op,
  output logic                       busy,
  input  leb_pkg::stat_t             stat,
  output leb_pkg::ctrl_t             ctrl
);

  logic [leb_pkg::UA_W-1:0] pc_r, pc_nxt;
  logic                     busy_r, busy_nxt;
  leb_pkg::ucode_t          word;
  logic                     cond_hit;

  assign word = leb_pkg::ucode_rom(pc_r);
  assign busy = busy_r;

  always_comb begin
    case (word.cond)
      leb_pkg::C_NONE:       cond_hit = 1'b0;
      leb_pkg::C_ALWAYS:     cond_hit = 1'b1;
      leb_pkg::C_FULL:       cond_hit = stat.full;
      leb_pkg::C_CARET_ZERO: cond_hit = stat.caret_zero;
      leb_pkg::C_CARET_END:  cond_hit = stat.caret_end;
      leb_pkg::C_MORE_INS:   cond_hit = stat.more_ins;
      leb_pkg::C_MORE_DEL:   cond_hit = stat.more_del;
      leb_pkg::C_OUT_BUSY:   cond_hit = stat.out_busy;
      default:               cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    ctrl        = '0;
    ctrl.accept = in_valid & ~busy_r;
    if (busy_r) begin
      ctrl.ptr_sel     = word.ptr_sel;
      ctrl.shift       = cond_hit ? word.shift : leb_pkg::SH_NONE;
      ctrl.wr_unit     = word.wr_unit;
      ctrl.len_op      = word.len_op;
      ctrl.caret_op    = word.caret_op;
      ctrl.set_commit  = word.set_commit;
      ctrl.set_cancel  = word.set_cancel;
      ctrl.set_refused = word.set_refused;
      ctrl.rd_issue    = word.rd_issue;
      ctrl.emit        = word.emit & ~stat.out_busy;
    end
  end

  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (ctrl.accept) begin
      pc_nxt   = leb_pkg::op_entry(in_op);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ctrl.emit) begin
        busy_nxt = 1'b0;
        pc_nxt   = leb_pkg::UA_DONE;
      end else if (cond_hit) begin
        pc_nxt = word.target;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= leb_pkg::UA_DONE;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

[design/leb_datapath.sv]
// ----------------------------------------------------------------------------
// leb_datapath: line store, caret/length registers and result register
// One write and one registered read per cycle; a shift moves one unit per
// cycle through a pending-write stage.
// ----------------------------------------------------------------------------
module leb_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  leb_pkg::ctrl_t               ctrl,
  output leb_pkg::stat_t               stat,
  input  logic [leb_pkg::UNIT_W-1:0]   in_unit,
  input  logic [leb_pkg::ADDR_W-1:0]   in_index,
  input  logic                         cfg_we,
  input  logic [leb_pkg::LEN_W-1:0]    cfg_wdata,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [leb_pkg::LEN_W-1:0]    out_length,
  output logic [leb_pkg::LEN_W-1:0]    out_caret_pos,
  output logic                         out_committed_flag,
  output logic                         out_cancelled_flag,
  output logic                         out_insert_refused,
  output logic [leb_pkg::UNIT_W-1:0]   out_read_unit
);

  localparam int LW = leb_pkg::LEN_W;
  localparam int AW = leb_pkg::ADDR_W;
  localparam int UW = leb_pkg::UNIT_W;

  logic [UW-1:0] mem [leb_pkg::MAX_UNITS];

  logic [LW-1:0] max_len_r, max_len_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] caret_r, caret_nxt;
  logic          commit_r, cancel_r, refused_r, rd_ok_r;
  logic [LW-1:0] ptr_r, ptr_nxt;
  logic          pend_r;
  logic [AW-1:0] pend_addr_r;
  logic [UW-1:0] unit_r, rdata_r;
  logic [AW-1:0] index_r;
  logic [LW-1:0] neighbor, cfg_max, cfg_len;
  logic          shifting;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [UW-1:0] wr_data;

  logic          out_valid_r;
  logic [LW-1:0] out_length_r, out_caret_r;
  logic          out_commit_r, out_cancel_r, out_refused_r;
  logic [UW-1:0] out_read_r;

  assign shifting = (ctrl.shift != leb_pkg::SH_NONE);
  assign neighbor = (ctrl.shift == leb_pkg::SH_INS) ? (ptr_r - 1'b1) : (ptr_r + 1'b1);

  always_comb begin
    stat.full       = (len_r >= max_len_r);
    stat.caret_zero = (caret_r == '0);
    stat.caret_end  = (caret_r == len_r);
    stat.more_ins   = (ptr_r > caret_r);
    stat.more_del   = (({1'b0, ptr_r} + 1'b1) < {1'b0, len_r});
    stat.out_busy   = out_valid_r & out_stall;
  end

  // write port: pending shift write, else the inserted unit
  always_comb begin
    wr_en   = pend_r | ctrl.wr_unit;
    wr_addr = pend_r ? pend_addr_r : caret_r[AW-1:0];
    wr_data = pend_r ? rdata_r : unit_r;
    rd_en   = shifting | ctrl.rd_issue;
    rd_addr = shifting ? neighbor[AW-1:0] : index_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_comb begin
    case (ctrl.ptr_sel)
      leb_pkg::PTR_LEN:      ptr_nxt = len_r;
      leb_pkg::PTR_CARET:    ptr_nxt = caret_r;
      leb_pkg::PTR_CARET_M1: ptr_nxt = caret_r - 1'b1;
      default:               ptr_nxt = ptr_r;
    endcase
    if (shifting) begin
      ptr_nxt = neighbor;
    end
  end

  assign cfg_max = leb_pkg::clamp_max(cfg_wdata);
  assign cfg_len = (len_r > cfg_max) ? cfg_max : len_r;

  always_comb begin
    max_len_nxt = max_len_r;
    len_nxt     = len_r;
    caret_nxt   = caret_r;
    if (cfg_we) begin
      max_len_nxt = cfg_max;
      len_nxt     = cfg_len;
      caret_nxt   = (caret_r > cfg_len) ? cfg_len : caret_r;
    end else begin
      case (ctrl.len_op)
        leb_pkg::LEN_INC: len_nxt = len_r + 1'b1;
        leb_pkg::LEN_DEC: len_nxt = len_r - 1'b1;
        default:          len_nxt = len_r;
      endcase
      case (ctrl.caret_op)
        leb_pkg::CAR_INC:    caret_nxt = caret_r + 1'b1;
        leb_pkg::CAR_DEC:    caret_nxt = caret_r - 1'b1;
        leb_pkg::CAR_ZERO:   caret_nxt = '0;
        leb_pkg::CAR_TO_LEN: caret_nxt = len_r;
        leb_pkg::CAR_RIGHT:  caret_nxt = (caret_r < len_r) ? caret_r + 1'b1 : caret_r;
        leb_pkg::CAR_LEFT:   caret_nxt = (caret_r != '0) ? caret_r - 1'b1 : caret_r;
        default:             caret_nxt = caret_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= leb_pkg::MAX_LEN_RST;
      len_r     <= '0;
      caret_r   <= '0;
      commit_r  <= 1'b0;
      cancel_r  <= 1'b0;
      refused_r <= 1'b0;
      rd_ok_r   <= 1'b0;
      pend_r    <= 1'b0;
    end else begin
      max_len_r <= max_len_nxt;
      len_r     <= len_nxt;
      caret_r   <= caret_nxt;
      pend_r    <= shifting;
      if (ctrl.set_commit) begin
        commit_r <= 1'b1;
      end
      if (ctrl.set_cancel) begin
        cancel_r <= 1'b1;
      end
      if (ctrl.accept) begin
        refused_r <= 1'b0;
        rd_ok_r   <= 1'b0;
      end else begin
        if (ctrl.set_refused) begin
          refused_r <= 1'b1;
        end
        if (ctrl.rd_issue) begin
          rd_ok_r <= ({1'b0, index_r} < len_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    pend_addr_r <= ptr_r[AW-1:0];
    if (ctrl.accept) begin
      unit_r  <= in_unit;
      index_r <= in_index;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_length_r  <= len_r;
      out_caret_r   <= caret_r;
      out_commit_r  <= commit_r;
      out_cancel_r  <= cancel_r;
      out_refused_r <= refused_r;
      out_read_r    <= rd_ok_r ? rdata_r : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_length         = out_length_r;
  assign out_caret_pos      = out_caret_r;
  assign out_committed_flag = out_commit_r;
  assign out_cancelled_flag = out_cancel_r;
  assign out_insert_refused = out_refused_r;
  assign out_read_unit      = out_read_r;

endmodule

[design/line_edit_buffer_unit.sv]
// ----------------------------------------------------------------------------
// line_edit_buffer_unit: bounded text line with caret, one edit per request
// Top level joining the microprogram sequencer and the line datapath.
// ----------------------------------------------------------------------------
// Each input request carries an edit command (insert, backspace, delete,
// caret moves, commit, cancel, read) and produces exactly one result request
// with the length, caret, sticky flags, an insert-refused bit and read data.
// Requests are processed one at a time. Insert, backspace and delete run
// longer the more units lie behind the caret, since the tail shift moves
// one unit per cycle through the line store's single write port and
// registered read port. A finished result sits in the output register, so a
// new request can be accepted while it waits; a later result that is ready
// while the earlier one is still stalled holds the block busy until the
// output register frees. cfg_wdata sets the maximum length (0 or above 64
// means 64) and clamps length and caret; write it only while the block is
// idle. The line store is not cleared at reset; only stored units are read.
// ----------------------------------------------------------------------------
module line_edit_buffer_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [leb_pkg::OP_W-1:0]     in_op,
  input  logic [leb_pkg::UNIT_W-1:0]   in_unit,
  input  logic [leb_pkg::ADDR_W-1:0]   in_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [leb_pkg::LEN_W-1:0]    out_length,
  output logic [leb_pkg::LEN_W-1:0]    out_caret_pos,
  output logic                         out_committed_flag,
  output logic                         out_cancelled_flag,
  output logic                         out_insert_refused,
  output logic [leb_pkg::UNIT_W-1:0]   out_read_unit,
  input  logic                         cfg_we,
  input  logic [leb_pkg::LEN_W-1:0]    cfg_wdata
);

  leb_pkg::ctrl_t ctrl;
  leb_pkg::stat_t stat;
  logic           busy;

  // stall while a request is in the program
  assign in_stall = busy;

  leb_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .busy     (busy),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  leb_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctrl               (ctrl),
    .stat               (stat),
    .in_unit            (in_unit),
    .in_index           (in_index),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_length         (out_length),
    .out_caret_pos      (out_caret_pos),
    .out_committed_flag (out_committed_flag),
    .out_cancelled_flag (out_cancelled_flag),
    .out_insert_refused (out_insert_refused),
    .out_read_unit      (out_read_unit)
  );

endmodule

[design/leb_checker.sv]
// ----------------------------------------------------------------------------
// leb_checker: port-level checks for line_edit_buffer_unit
// Watches the result channel for consistent line state.
// ----------------------------------------------------------------------------
module leb_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [leb_pkg::LEN_W-1:0]    out_length,
  input logic [leb_pkg::LEN_W-1:0]    out_caret_pos,
  input logic                         out_insert_refused
);

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_length <= leb_pkg::MAX_LEN_RST))
    else $error("result length beyond store size");

  a_caret_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_caret_pos <= out_length))
    else $error("caret past end of line");

  // a refused insert means the line was full, so never empty
  a_refuse_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_insert_refused) |-> (out_length != '0))
    else $error("insert refused on empty line");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && out_valid && out_stall) |=>
      (out_valid && $stable(out_length) && $stable(out_caret_pos)))
    else $error("stalled result changed");

endmodule

bind line_edit_buffer_unit leb_checker u_leb_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_length         (out_length),
  .out_caret_pos      (out_caret_pos),
  .out_insert_refused (out_insert_refused)
);
